// ===== hdl/ksl_pkg.sv =====
// shared types, codes and helpers for the keypad sequence lock
`timescale 1ns / 1ps

package ksl_pkg;

   localparam int TIME_W    = 32;
   localparam int KEY_W     = 3;
   localparam int PROG_W    = 3;
   localparam int SEQ_W     = 12;
   localparam int SEQ_CODES = SEQ_W / KEY_W;
   localparam int SEQ_LEN   = 4;   // steps in the unlock sequence, 1 to 4
   localparam int CSR_IDX_W = 2;
   localparam int REQ_W     = 40;
   localparam int RSP_W     = 8;

   localparam logic [TIME_W-1:0] AUTO_LOCK_RESET  = 32'd60000;
   localparam logic [TIME_W-1:0] PANIC_HOLD_RESET = 32'd3000;
   localparam logic [SEQ_W-1:0]  UNLOCK_SEQ_RESET = 12'd2697;

   typedef enum logic [2:0] {
      CMD_KEY      = 3'd0,
      CMD_TICK     = 3'd1,
      CMD_ACTIVITY = 3'd2,
      CMD_LOCK     = 3'd3,
      CMD_INIT     = 3'd4,
      CMD_UNLOCK   = 3'd5
   } cmd_type;

   typedef enum logic [CSR_IDX_W-1:0] {
      CSR_AUTO_LOCK  = 2'd0,
      CSR_PANIC_HOLD = 2'd1,
      CSR_UNLOCK_SEQ = 2'd2
   } csr_index_type;

   localparam logic [KEY_W-1:0] KEY_CENTER = 3'd0;
   localparam logic [KEY_W-1:0] KEY_LEFT   = 3'd3;

   typedef struct packed {
      logic [TIME_W-1:0] auto_lock_ms;
      logic [TIME_W-1:0] hold_limit_ms;
      logic [SEQ_W-1:0]  unlock_sequence;
   } cfg_type;

   typedef struct packed {
      logic [TIME_W-1:0] now_ms;
      logic [KEY_W-1:0]  key_code;
      logic [2:0]        cmd;
   } item_type;

   typedef struct packed {
      logic              ready;
      logic              locked_flag;
      logic              panic_flag;
      logic [PROG_W-1:0] match_progress;
      logic              hold_active;
      logic [TIME_W-1:0] hold_start_ms;
      logic [TIME_W-1:0] last_activity_ms;
   } state_type;

   // consumed in bit 0 up to autolock_pulse in bit 5
   typedef struct packed {
      logic autolock_pulse;
      logic unlock_pulse;
      logic panic_pulse;
      logic is_panicked;
      logic is_locked;
      logic consumed;
   } result_type;

   // key code of one step, center beyond the register
   function automatic logic [KEY_W-1:0] seq_code(input logic [SEQ_W-1:0] seq,
                                                input logic [PROG_W-1:0] step);
      logic [KEY_W-1:0] code;
      code = KEY_CENTER;
      for (int i = 0; i < SEQ_CODES; i++) begin
         if (step == PROG_W'(i)) begin
            code = seq[i*KEY_W +: KEY_W];
         end
      end
      return code;
   endfunction

endpackage

// ===== hdl/ksl_step.sv =====
// next state and result word for one command of the sequence lock
`timescale 1ns / 1ps

module ksl_step (
   input  ksl_pkg::cfg_type    cfg,
   input  ksl_pkg::state_type  cur,
   input  ksl_pkg::item_type   item,
   output ksl_pkg::state_type  nxt,
   output ksl_pkg::result_type res
);

   logic [ksl_pkg::TIME_W-1:0] hold_elapsed;
   logic [ksl_pkg::TIME_W-1:0] idle_elapsed;
   logic [ksl_pkg::PROG_W:0]   prog_inc;
   logic                       consumed;
   logic                       panic_p;
   logic                       unlock_p;
   logic                       auto_p;

   assign hold_elapsed = item.now_ms - cur.hold_start_ms;
   assign idle_elapsed = item.now_ms - cur.last_activity_ms;
   assign prog_inc     = {1'b0, cur.match_progress} + 4'd1;

   always_comb begin
      nxt      = cur;
      consumed = 1'b0;
      panic_p  = 1'b0;
      unlock_p = 1'b0;
      auto_p   = 1'b0;
      case (item.cmd)
         ksl_pkg::CMD_KEY: begin
            if (!cur.ready) begin
               consumed = 1'b0;
            end else if (cur.panic_flag) begin
               consumed = 1'b1;
            end else if (!cur.locked_flag) begin
               consumed = 1'b0;
            end else if (item.key_code == ksl_pkg::KEY_LEFT && cur.hold_active &&
                         hold_elapsed >= cfg.hold_limit_ms) begin
               nxt.panic_flag     = 1'b1;
               nxt.locked_flag    = 1'b1;
               nxt.match_progress = '0;
               nxt.hold_active    = 1'b0;
               panic_p            = 1'b1;
               consumed           = 1'b1;
            end else begin
               if (item.key_code == ksl_pkg::KEY_LEFT) begin
                  if (!cur.hold_active) begin
                     nxt.hold_active   = 1'b1;
                     nxt.hold_start_ms = item.now_ms;
                  end
               end else begin
                  nxt.hold_active = 1'b0;
               end
               if (item.key_code == ksl_pkg::KEY_CENTER) begin
                  consumed = 1'b1;
               end else if (item.key_code ==
                            ksl_pkg::seq_code(cfg.unlock_sequence, cur.match_progress)) begin
                  if (prog_inc >= 4'(ksl_pkg::SEQ_LEN)) begin
                     // sequence complete
                     nxt.locked_flag      = 1'b0;
                     nxt.panic_flag       = 1'b0;
                     nxt.match_progress   = '0;
                     nxt.hold_active      = 1'b0;
                     nxt.last_activity_ms = item.now_ms;
                     unlock_p             = 1'b1;
                     consumed             = 1'b0;
                  end else begin
                     nxt.match_progress = prog_inc[ksl_pkg::PROG_W-1:0];
                     consumed           = 1'b1;
                  end
               end else begin
                  // wrong key may still start the sequence over
                  nxt.match_progress = (item.key_code ==
                     ksl_pkg::seq_code(cfg.unlock_sequence, '0)) ? 3'd1 : 3'd0;
                  consumed = 1'b1;
               end
            end
         end
         ksl_pkg::CMD_TICK: begin
            if (cur.ready && !cur.panic_flag && !cur.locked_flag &&
                cfg.auto_lock_ms != '0 && idle_elapsed >= cfg.auto_lock_ms) begin
               nxt.locked_flag    = 1'b1;
               nxt.match_progress = '0;
               nxt.hold_active    = 1'b0;
               auto_p             = 1'b1;
            end
         end
         ksl_pkg::CMD_ACTIVITY: begin
            nxt.last_activity_ms = item.now_ms;
         end
         ksl_pkg::CMD_LOCK: begin
            nxt.locked_flag    = 1'b1;
            nxt.match_progress = '0;
            nxt.hold_active    = 1'b0;
         end
         ksl_pkg::CMD_INIT: begin
            nxt.last_activity_ms = item.now_ms;
            nxt.locked_flag      = 1'b1;
            nxt.panic_flag       = 1'b0;
            nxt.match_progress   = '0;
            nxt.hold_active      = 1'b0;
            nxt.ready            = 1'b1;
         end
         ksl_pkg::CMD_UNLOCK: begin
            nxt.locked_flag      = 1'b0;
            nxt.panic_flag       = 1'b0;
            nxt.match_progress   = '0;
            nxt.hold_active      = 1'b0;
            nxt.last_activity_ms = item.now_ms;
         end
         default: begin
            nxt = cur;
         end
      endcase
   end

   always_comb begin
      res.consumed       = consumed;
      res.is_locked      = nxt.locked_flag | nxt.panic_flag;
      res.is_panicked    = nxt.panic_flag;
      res.panic_pulse    = panic_p;
      res.unlock_pulse   = unlock_p;
      res.autolock_pulse = auto_p;
   end

endmodule

// ===== hdl/key_sequence_lock_with_panic_core.sv =====
// top level of the keypad sequence lock with panic hold
`timescale 1ns / 1ps

// channel  | dir | handshake              | payload
// req      | in  | req_tvalid/req_tready  | req_tdata: cmd, key_code, now_ms
// rsp      | out | rsp_tvalid/rsp_tready  | rsp_tdata: six status and pulse bits
// csr      | in  | csr_valid/csr_ready    | csr_index, csr_data
//
// one word per cycle sustained while rsp_tready stays high; an accepted word passes from stage one into rsp
// stage one holds the accepted word, the step logic (two 32-bit subtracts and
// compares) writes lock state and the rsp register in the same edge
// rsp stall holds the result register and backs stage one up, req_tready drops
// only when both are full and rsp_tready is low
// reset is synchronous, active high: locked, not ready, no panic, registers at
// their default values; csr writes are always taken

module key_sequence_lock_with_panic_core (
   input  logic                           clock,
   input  logic                           reset,
   input  logic                           req_tvalid,
   output logic                           req_tready,
   // [2:0] cmd, [5:3] key_code, [37:6] now_ms, [39:38] zero
   input  logic [ksl_pkg::REQ_W-1:0]      req_tdata,
   output logic                           rsp_tvalid,
   input  logic                           rsp_tready,
   // [0] consumed, [1] is_locked, [2] is_panicked, [3] panic_pulse,
   // [4] unlock_pulse, [5] autolock_pulse, [7:6] zero
   output logic [ksl_pkg::RSP_W-1:0]      rsp_tdata,
   input  logic                           csr_valid,
   output logic                           csr_ready,
   input  logic [ksl_pkg::CSR_IDX_W-1:0]  csr_index,
   input  logic [ksl_pkg::TIME_W-1:0]     csr_data
);

   ksl_pkg::cfg_type    cfg_ff;
   ksl_pkg::state_type  state_ff;
   ksl_pkg::state_type  state_in;
   ksl_pkg::item_type   item_ff;
   ksl_pkg::result_type res_in;
   ksl_pkg::result_type rsp_data_ff;
   logic                item_valid_ff;
   logic                rsp_valid_ff;
   logic                advance;
   logic                req_accept;

   // stage one moves into the rsp register when that register is free or drains
   assign advance    = item_valid_ff & (~rsp_valid_ff | rsp_tready);
   assign req_tready = ~item_valid_ff | advance;
   assign req_accept = req_tvalid & req_tready;
   assign csr_ready  = 1'b1;

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = {2'b00, rsp_data_ff};

   // configuration registers
   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.auto_lock_ms    <= ksl_pkg::AUTO_LOCK_RESET;
         cfg_ff.hold_limit_ms   <= ksl_pkg::PANIC_HOLD_RESET;
         cfg_ff.unlock_sequence <= ksl_pkg::UNLOCK_SEQ_RESET;
      end else if (csr_valid) begin
         case (csr_index)
            ksl_pkg::CSR_AUTO_LOCK:  cfg_ff.auto_lock_ms    <= csr_data;
            ksl_pkg::CSR_PANIC_HOLD: cfg_ff.hold_limit_ms   <= csr_data;
            ksl_pkg::CSR_UNLOCK_SEQ: cfg_ff.unlock_sequence <= csr_data[ksl_pkg::SEQ_W-1:0];
            default: ;   // index outside the register list is dropped
         endcase
      end
   end

   // stage one: accepted word
   always_ff @(posedge clock) begin
      if (reset) begin
         item_valid_ff <= 1'b0;
      end else if (req_tready) begin
         item_valid_ff <= req_tvalid;
      end
   end

   always_ff @(posedge clock) begin
      if (req_accept) begin
         item_ff <= req_tdata[ksl_pkg::REQ_W-3:0];
      end
   end

   ksl_step u_step (
      .cfg  (cfg_ff),
      .cur  (state_ff),
      .item (item_ff),
      .nxt  (state_in),
      .res  (res_in)
   );

   // lock state advances with each word leaving stage one
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff.ready            <= 1'b0;
         state_ff.locked_flag      <= 1'b1;
         state_ff.panic_flag       <= 1'b0;
         state_ff.match_progress   <= '0;
         state_ff.hold_active      <= 1'b0;
         state_ff.hold_start_ms    <= '0;
         state_ff.last_activity_ms <= '0;
      end else if (advance) begin
         state_ff <= state_in;
      end
   end

   // result register
   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (advance) begin
         rsp_valid_ff <= 1'b1;
      end else if (rsp_tready) begin
         rsp_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (advance) begin
         rsp_data_ff <= res_in;
      end
   end

   // panic always implies locked
   assert property (@(posedge clock) disable iff (reset)
      state_ff.panic_flag |-> state_ff.locked_flag)
      else $error("panic without lock");

   // no hold runs while unlocked or panicked
   assert property (@(posedge clock) disable iff (reset)
      (!state_ff.locked_flag || state_ff.panic_flag) |-> !state_ff.hold_active)
      else $error("hold running outside locked state");

   // progress never reaches the sequence length
   assert property (@(posedge clock) disable iff (reset)
      {1'b0, state_ff.match_progress} < 4'(ksl_pkg::SEQ_LEN))
      else $error("match progress out of range");

   // pulses agree with the state they report
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff |-> (!rsp_data_ff.panic_pulse ||
                        (rsp_data_ff.is_panicked && rsp_data_ff.is_locked)) &&
                       (!rsp_data_ff.unlock_pulse || !rsp_data_ff.is_locked))
      else $error("pulse disagrees with lock state");

   // a word in stage one is never dropped while stalled
   assert property (@(posedge clock) disable iff (reset)
      (item_valid_ff && !advance) |=> item_valid_ff)
      else $error("stalled word lost");

endmodule

// ===== tb/ksl_lock_checker.sv =====
// status word checker for the keypad sequence lock: watches all channels, predicts, compares
`timescale 1ns / 1ps

module ksl_lock_checker (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          req_tvalid,
   input  logic                          req_tready,
   input  logic [ksl_pkg::REQ_W-1:0]     req_tdata,
   input  logic                          rsp_tvalid,
   input  logic                          rsp_tready,
   input  logic [ksl_pkg::RSP_W-1:0]     rsp_tdata,
   input  logic                          csr_valid,
   input  logic                          csr_ready,
   input  logic [ksl_pkg::CSR_IDX_W-1:0] csr_index,
   input  logic [ksl_pkg::TIME_W-1:0]    csr_data,
   output int                            fail_count,
   output logic                          busy
);

   localparam logic [ksl_pkg::PROG_W-1:0] PROG_ONE = {{(ksl_pkg::PROG_W-1){1'b0}}, 1'b1};

   // register copy
   logic [ksl_pkg::TIME_W-1:0] auto_ms;
   logic [ksl_pkg::TIME_W-1:0] hold_ms;
   logic [ksl_pkg::SEQ_W-1:0]  code_seq;

   // lock state copy
   logic                       armed;
   logic                       locked;
   logic                       panicked;
   logic                       holding;
   logic [ksl_pkg::PROG_W-1:0] progress;
   logic [ksl_pkg::TIME_W-1:0] hold_t0;
   logic [ksl_pkg::TIME_W-1:0] last_act;

   ksl_pkg::result_type status_due_q[$];

   initial begin
      fail_count = 0;
      busy       = 1'b0;
   end

   // steps past the register read as center
   function automatic logic [ksl_pkg::KEY_W-1:0] step_code(
      input logic [ksl_pkg::PROG_W-1:0] step);
      if (step < ksl_pkg::SEQ_CODES) begin
         return code_seq[step*ksl_pkg::KEY_W +: ksl_pkg::KEY_W];
      end
      return ksl_pkg::KEY_CENTER;
   endfunction

   function automatic void engage_lock();
      locked   = 1'b1;
      progress = '0;
      holding  = 1'b0;
   endfunction

   function automatic void release_lock(input logic [ksl_pkg::TIME_W-1:0] now);
      locked   = 1'b0;
      panicked = 1'b0;
      progress = '0;
      holding  = 1'b0;
      last_act = now;
   endfunction

   // advances the lock state by one word and returns the status it should give
   function automatic ksl_pkg::result_type lock_status_next(input ksl_pkg::item_type it);
      ksl_pkg::result_type        r;
      logic [ksl_pkg::PROG_W-1:0] nxt;
      r = '0;
      case (it.cmd)
         ksl_pkg::CMD_KEY: begin
            if (!armed) begin
               r.consumed = 1'b0;
            end else if (panicked) begin
               r.consumed = 1'b1;
            end else if (!locked) begin
               r.consumed = 1'b0;
            end else if (it.key_code == ksl_pkg::KEY_LEFT && holding &&
                         (it.now_ms - hold_t0) >= hold_ms) begin
               panicked      = 1'b1;
               engage_lock();
               r.panic_pulse = 1'b1;
               r.consumed    = 1'b1;
            end else begin
               if (it.key_code == ksl_pkg::KEY_LEFT) begin
                  if (!holding) begin
                     holding = 1'b1;
                     hold_t0 = it.now_ms;
                  end
               end else begin
                  holding = 1'b0;
               end
               if (it.key_code == ksl_pkg::KEY_CENTER) begin
                  r.consumed = 1'b1;
               end else if (it.key_code == step_code(progress)) begin
                  nxt = progress + 1'b1;
                  if (nxt >= ksl_pkg::SEQ_LEN || nxt == '0) begin
                     release_lock(it.now_ms);
                     r.unlock_pulse = 1'b1;
                  end else begin
                     progress   = nxt;
                     r.consumed = 1'b1;
                  end
               end else begin
                  progress   = (it.key_code == step_code('0)) ? PROG_ONE : '0;
                  r.consumed = 1'b1;
               end
            end
         end
         ksl_pkg::CMD_TICK: begin
            if (armed && !panicked && !locked && auto_ms != '0 &&
                (it.now_ms - last_act) >= auto_ms) begin
               engage_lock();
               r.autolock_pulse = 1'b1;
            end
         end
         ksl_pkg::CMD_ACTIVITY: last_act = it.now_ms;
         ksl_pkg::CMD_LOCK:     engage_lock();
         ksl_pkg::CMD_INIT: begin
            last_act = it.now_ms;
            panicked = 1'b0;
            engage_lock();
            armed    = 1'b1;
         end
         ksl_pkg::CMD_UNLOCK:   release_lock(it.now_ms);
         default: ;
      endcase
      r.is_locked   = locked | panicked;
      r.is_panicked = panicked;
      return r;
   endfunction

   task automatic compare_field(input string name, input logic [1:0] want,
                                input logic [1:0] got);
      if (want !== got) begin
         fail_count++;
         $display("%0t ns: %s expected %0d actual %0d", $time, name, want, got);
      end
   endtask

   always @(posedge clock) begin
      ksl_pkg::result_type want;
      ksl_pkg::result_type got;
      if (reset) begin
         auto_ms  = ksl_pkg::AUTO_LOCK_RESET;
         hold_ms  = ksl_pkg::PANIC_HOLD_RESET;
         code_seq = ksl_pkg::UNLOCK_SEQ_RESET;
         armed    = 1'b0;
         locked   = 1'b1;
         panicked = 1'b0;
         progress = '0;
         holding  = 1'b0;
         hold_t0  = '0;
         last_act = '0;
         status_due_q.delete();
         busy <= 1'b0;
      end else begin
         if (csr_valid && csr_ready) begin
            case (csr_index)
               ksl_pkg::CSR_AUTO_LOCK:  auto_ms  = csr_data;
               ksl_pkg::CSR_PANIC_HOLD: hold_ms  = csr_data;
               ksl_pkg::CSR_UNLOCK_SEQ: code_seq = csr_data[ksl_pkg::SEQ_W-1:0];
               default: ;
            endcase
         end
         if (req_tvalid && req_tready) begin
            status_due_q.push_back(lock_status_next(
               ksl_pkg::item_type'(req_tdata[$bits(ksl_pkg::item_type)-1:0])));
         end
         if (rsp_tvalid && rsp_tready) begin
            if (status_due_q.size() == 0) begin
               fail_count++;
               $display("%0t ns: status word expected none actual %0h", $time, rsp_tdata);
            end else begin
               want = status_due_q.pop_front();
               got  = ksl_pkg::result_type'(rsp_tdata[$bits(ksl_pkg::result_type)-1:0]);
               compare_field("consumed", {1'b0, want.consumed}, {1'b0, got.consumed});
               compare_field("is_locked", {1'b0, want.is_locked}, {1'b0, got.is_locked});
               compare_field("is_panicked", {1'b0, want.is_panicked},
                             {1'b0, got.is_panicked});
               compare_field("panic_pulse", {1'b0, want.panic_pulse},
                             {1'b0, got.panic_pulse});
               compare_field("unlock_pulse", {1'b0, want.unlock_pulse},
                             {1'b0, got.unlock_pulse});
               compare_field("autolock_pulse", {1'b0, want.autolock_pulse},
                             {1'b0, got.autolock_pulse});
               compare_field("pad bits", 2'b00,
                             rsp_tdata[ksl_pkg::RSP_W-1:$bits(ksl_pkg::result_type)]);
            end
         end
         busy <= (status_due_q.size() != 0);
      end
   end

endmodule

// ===== tb/tb_key_sequence_lock_with_panic_core.sv =====
// testbench top for the keypad sequence lock: clock, reset, word stimulus and verdict
`timescale 1ns / 1ps

module tb_key_sequence_lock_with_panic_core;

   localparam int PHASES      = 7;
   localparam int PHASE_WORDS = 215;

   logic                          clock      = 1'b0;
   logic                          reset      = 1'b1;
   logic                          req_tvalid = 1'b0;
   logic                          req_tready;
   // [2:0] cmd, [5:3] key_code, [37:6] now_ms, [39:38] zero
   logic [ksl_pkg::REQ_W-1:0]     req_tdata  = '0;
   logic                          rsp_tvalid;
   logic                          rsp_tready = 1'b0;
   // [0] consumed, [1] is_locked, [2] is_panicked, [3] panic_pulse,
   // [4] unlock_pulse, [5] autolock_pulse, [7:6] zero
   logic [ksl_pkg::RSP_W-1:0]     rsp_tdata;
   logic                          csr_valid  = 1'b0;
   logic                          csr_ready;
   logic [ksl_pkg::CSR_IDX_W-1:0] csr_index  = '0;
   logic [ksl_pkg::TIME_W-1:0]    csr_data   = '0;

   int   lock_fail_count;
   logic status_busy;

   // idling on both sides is enabled per stretch of the run
   logic idle_on    = 1'b1;
   int   stall_left = 0;
   int   sent_words = 0;

   // stimulus copy of the registers, used to shape well-formed sequences
   logic [ksl_pkg::TIME_W-1:0] cur_auto = ksl_pkg::AUTO_LOCK_RESET;
   logic [ksl_pkg::TIME_W-1:0] cur_hold = ksl_pkg::PANIC_HOLD_RESET;
   logic [ksl_pkg::SEQ_W-1:0]  cur_seq  = ksl_pkg::UNLOCK_SEQ_RESET;
   logic [ksl_pkg::TIME_W-1:0] t_ms     = '0;

   key_sequence_lock_with_panic_core u_top (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .csr_valid  (csr_valid),
      .csr_ready  (csr_ready),
      .csr_index  (csr_index),
      .csr_data   (csr_data)
   );

   ksl_lock_checker u_chk (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .csr_valid  (csr_valid),
      .csr_ready  (csr_ready),
      .csr_index  (csr_index),
      .csr_data   (csr_data),
      .fail_count (lock_fail_count),
      .busy       (status_busy)
   );

   always #4 clock = ~clock;

   // hard stop well past the slowest correct run
   initial begin
      #5_000_000;
      $display("[key_sequence_lock_with_panic_core] ERROR");
      $finish;
   end

   // receiver side: random stall bursts while idling is on
   always @(posedge clock) begin
      if (stall_left != 0) begin
         stall_left <= stall_left - 1;
         rsp_tready <= 1'b0;
      end else if (idle_on && $urandom_range(0, 4) == 0) begin
         stall_left <= $urandom_range(0, 3);
         rsp_tready <= 1'b0;
      end else begin
         rsp_tready <= 1'b1;
      end
   end

   // one word on req, with an optional gap first; valid stays up for the next word
   task automatic push_word(input logic [2:0] cmd, input logic [ksl_pkg::KEY_W-1:0] key,
                            input logic [ksl_pkg::TIME_W-1:0] now);
      if (idle_on && $urandom_range(0, 3) == 0) begin
         req_tvalid <= 1'b0;
         repeat ($urandom_range(1, 4)) @(posedge clock);
      end
      req_tvalid <= 1'b1;
      req_tdata  <= {2'b00, now, key, cmd};
      @(posedge clock);
      while (!req_tready) @(posedge clock);
      sent_words++;
   endtask

   // hold off until every status word is back, then let the pipe settle
   task automatic drain();
      req_tvalid <= 1'b0;
      @(posedge clock);
      while (status_busy) @(posedge clock);
      repeat (4) @(posedge clock);
   endtask

   task automatic write_csr(input ksl_pkg::csr_index_type idx,
                            input logic [ksl_pkg::TIME_W-1:0] value);
      csr_valid <= 1'b1;
      csr_index <= idx;
      csr_data  <= value;
      @(posedge clock);
      while (!csr_ready) @(posedge clock);
   endtask

   task automatic program_regs(input logic [ksl_pkg::TIME_W-1:0] auto_v,
                               input logic [ksl_pkg::TIME_W-1:0] hold_v,
                               input logic [ksl_pkg::SEQ_W-1:0] seq_v);
      cur_auto = auto_v;
      cur_hold = hold_v;
      cur_seq  = seq_v;
      write_csr(ksl_pkg::CSR_AUTO_LOCK, auto_v);
      write_csr(ksl_pkg::CSR_PANIC_HOLD, hold_v);
      write_csr(ksl_pkg::CSR_UNLOCK_SEQ, {{(ksl_pkg::TIME_W-ksl_pkg::SEQ_W){1'b0}}, seq_v});
      csr_valid <= 1'b0;
   endtask

   // mostly real keys 1..7, now and then any code including center
   function automatic logic [ksl_pkg::SEQ_W-1:0] pick_sequence();
      logic [ksl_pkg::SEQ_W-1:0] s;
      s = '0;
      for (int i = 0; i < ksl_pkg::SEQ_CODES; i++) begin
         s[i*ksl_pkg::KEY_W +: ksl_pkg::KEY_W] =
            ($urandom_range(0, 7) == 0) ? 3'($urandom_range(0, 7))
                                        : 3'($urandom_range(1, 7));
      end
      return s;
   endfunction

   initial begin
      int                         pick;
      int                         phase_end;
      logic [ksl_pkg::TIME_W-1:0] dt;
      logic [ksl_pkg::KEY_W-1:0]  key;

      repeat (4) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // --- directed part, default registers (sequence up, up, down, press) ---
      // before init: keys and ticks are ignored, unlock and lock still act
      push_word(ksl_pkg::CMD_KEY, 3'd1, 32'd0);
      push_word(ksl_pkg::CMD_TICK, 3'd7, 32'hFFFF_FFFF);
      push_word(ksl_pkg::CMD_UNLOCK, 3'd0, 32'd5);
      push_word(ksl_pkg::CMD_LOCK, 3'd0, 32'd6);
      push_word(ksl_pkg::CMD_ACTIVITY, 3'd7, 32'hFFFF_FFFF);
      // unused command codes
      push_word(3'd6, 3'd0, 32'd7);
      push_word(3'd7, 3'd7, 32'hFFFF_FFFF);
      push_word(ksl_pkg::CMD_INIT, 3'd0, 32'd100);
      // center swallowed, wrong third key that equals the first code restarts at one
      push_word(ksl_pkg::CMD_KEY, ksl_pkg::KEY_CENTER, 32'd110);
      push_word(ksl_pkg::CMD_KEY, 3'd1, 32'd120);
      push_word(ksl_pkg::CMD_KEY, 3'd1, 32'd130);
      push_word(ksl_pkg::CMD_KEY, 3'd1, 32'd140);
      push_word(ksl_pkg::CMD_KEY, 3'd1, 32'd150);
      push_word(ksl_pkg::CMD_KEY, 3'd2, 32'd160);
      push_word(ksl_pkg::CMD_KEY, 3'd5, 32'd170);
      // unlocked: keys pass through, then ticks just before and at the auto lock timeout
      push_word(ksl_pkg::CMD_KEY, 3'd4, 32'd180);
      push_word(ksl_pkg::CMD_TICK, 3'd0, 32'd170 + ksl_pkg::AUTO_LOCK_RESET - 1);
      push_word(ksl_pkg::CMD_TICK, 3'd0, 32'd170 + ksl_pkg::AUTO_LOCK_RESET);
      // left hold one short of the limit, then at the limit
      push_word(ksl_pkg::CMD_KEY, ksl_pkg::KEY_LEFT, 32'd100_000);
      push_word(ksl_pkg::CMD_KEY, ksl_pkg::KEY_LEFT,
                32'd100_000 + ksl_pkg::PANIC_HOLD_RESET - 1);
      push_word(ksl_pkg::CMD_KEY, ksl_pkg::KEY_LEFT, 32'd100_000 + ksl_pkg::PANIC_HOLD_RESET);
      push_word(ksl_pkg::CMD_KEY, 3'd7, 32'd100_500);
      push_word(ksl_pkg::CMD_TICK, 3'd0, 32'hFFFF_FFFF);
      // hold across the wrap of the millisecond time
      push_word(ksl_pkg::CMD_INIT, 3'd0, 32'hFFFF_FFF0);
      push_word(ksl_pkg::CMD_KEY, ksl_pkg::KEY_LEFT, 32'hFFFF_FFF0);
      push_word(ksl_pkg::CMD_KEY, ksl_pkg::KEY_LEFT, 32'hFFFF_FFF0 + ksl_pkg::PANIC_HOLD_RESET);
      push_word(ksl_pkg::CMD_UNLOCK, 3'd6, 32'd0);

      // --- random part, several register settings ---
      for (int phase = 0; phase < PHASES; phase++) begin
         if (phase != 0) begin
            drain();
            case (phase)
               1: program_regs('0, '0, pick_sequence());
               2: program_regs('1, '1, '1);
               3: program_regs($urandom_range(1, 2000), $urandom_range(1, 2000), '0);
               4: program_regs(32'd1, 32'd1, pick_sequence());
               5: program_regs($urandom, $urandom, pick_sequence());
               default: program_regs(ksl_pkg::AUTO_LOCK_RESET, ksl_pkg::PANIC_HOLD_RESET,
                                     ksl_pkg::UNLOCK_SEQ_RESET);
            endcase
            push_word(ksl_pkg::CMD_INIT, 3'($urandom_range(0, 7)), t_ms);
         end
         // no idling in the closing phase
         idle_on <= (phase != PHASES - 1);
         phase_end = sent_words + PHASE_WORDS;
         while (sent_words < phase_end) begin
            pick = $urandom_range(0, 99);
            if ($urandom_range(0, 19) == 0) begin
               t_ms = $urandom;
            end else begin
               t_ms = t_ms + $urandom_range(0, 50);
            end
            if (pick < 38) begin
               // unlock attempt, now and then from a clean start, a key now and then wrong
               if ($urandom_range(0, 2) == 0) begin
                  push_word(ksl_pkg::CMD_INIT, 3'($urandom_range(0, 7)), t_ms);
               end
               for (int s = 0; s < ksl_pkg::SEQ_LEN; s++) begin
                  key = cur_seq[s*ksl_pkg::KEY_W +: ksl_pkg::KEY_W];
                  if ($urandom_range(0, 9) == 0) begin
                     key = 3'($urandom_range(0, 7));
                  end
                  t_ms = t_ms + $urandom_range(1, 200);
                  push_word(ksl_pkg::CMD_KEY, key, t_ms);
               end
            end else if (pick < 55) begin
               // left hold ending near the panic limit, sometimes broken by another key
               push_word(ksl_pkg::CMD_KEY, ksl_pkg::KEY_LEFT, t_ms);
               if ($urandom_range(0, 3) == 0) begin
                  push_word(ksl_pkg::CMD_KEY, 3'($urandom_range(0, 7)), t_ms + 1);
               end
               case ($urandom_range(0, 3))
                  0:       dt = cur_hold - 1;
                  1:       dt = cur_hold;
                  2:       dt = cur_hold + 1;
                  default: dt = $urandom_range(0, 4000);
               endcase
               push_word(ksl_pkg::CMD_KEY, ksl_pkg::KEY_LEFT, t_ms + dt);
            end else if (pick < 67) begin
               // unlock marks activity, then ticks around the auto lock timeout
               push_word(ksl_pkg::CMD_UNLOCK, 3'($urandom_range(0, 7)), t_ms);
               case ($urandom_range(0, 3))
                  0:       dt = cur_auto + $urandom_range(0, 100);
                  1:       dt = $urandom;
                  default: dt = cur_auto;
               endcase
               push_word(ksl_pkg::CMD_TICK, 3'($urandom_range(0, 7)), t_ms + cur_auto - 1);
               push_word(ksl_pkg::CMD_TICK, 3'($urandom_range(0, 7)), t_ms + dt);
            end else if (pick < 74) begin
               push_word(ksl_pkg::CMD_INIT, 3'($urandom_range(0, 7)), t_ms);
            end else if (pick < 78) begin
               push_word(ksl_pkg::CMD_UNLOCK, 3'($urandom_range(0, 7)), t_ms);
            end else if (pick < 83) begin
               push_word(ksl_pkg::CMD_LOCK, 3'($urandom_range(0, 7)), t_ms);
            end else if (pick < 89) begin
               push_word(ksl_pkg::CMD_ACTIVITY, 3'($urandom_range(0, 7)), t_ms);
            end else if (pick < 95) begin
               push_word(ksl_pkg::CMD_KEY, 3'($urandom_range(0, 7)), t_ms);
            end else begin
               // noise: any command code, any key, any time
               push_word(3'($urandom_range(0, 7)), 3'($urandom_range(0, 7)), $urandom);
            end
            // sender holds back until all status words are in
            if ($urandom_range(0, 149) == 0) begin
               drain();
            end
            // switch idling off and on for stretches
            if (phase != PHASES - 1 && $urandom_range(0, 63) == 0) begin
               idle_on <= ~idle_on;
            end
         end
      end

      drain();
      repeat (8) @(posedge clock);
      if (lock_fail_count == 0) begin
         $display("[key_sequence_lock_with_panic_core] OK");
      end else begin
         $display("[key_sequence_lock_with_panic_core] ERROR");
      end
      $finish;
   end

endmodule
